// ===== rtl/core/sha256_double_hash_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// sha256 double hash engine assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef SHA256_DOUBLE_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA256_DOUBLE_HASH_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SHA256DE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define SHA256DE_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SHA256DE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHA256DE_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/sha256de_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256de_pkg
// shared types, constants and control structs of the sha256 double hash engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha256de_pkg;

	typedef logic [31:0] word_t;
	// eight 32-bit words, index 0 is word a / h0
	typedef logic [7:0][31:0] hash_t;

	localparam int unsigned ROUND_W = 6;
	localparam int unsigned POS_W = 4;
	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(63);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(15);

	// initial chain value, element 0 in the low word
	localparam hash_t IV_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// padding words of the one-block second pass over a 256-bit digest
	localparam word_t PAD_FIRST = 32'h80000000;
	localparam word_t PAD_LEN = 32'h00000100;

	localparam word_t K_ROM [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// message schedule controls
	typedef struct packed {
		logic shift_in;
		logic expand;
		logic load_pad;
	} sched_ctl_t;

	// round unit controls
	typedef struct packed {
		logic load;
		logic step;
	} round_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/sha256de_sched.sv =====
// ----------------------------------------------------------------------------
// sha256de_sched
// 16-word message schedule window: takes input words, expands one word a round
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256de_sched (
	input  wire                      clk,
	input  sha256de_pkg::sched_ctl_t ctl,
	input  sha256de_pkg::word_t      in_word,
	input  sha256de_pkg::hash_t      pad_hash,
	output sha256de_pkg::word_t      w_cur
);

	function automatic sha256de_pkg::word_t small_sigma0(input sha256de_pkg::word_t x);
		small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic sha256de_pkg::word_t small_sigma1(input sha256de_pkg::word_t x);
		small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	// window slot 0 is the word used by the current round
	sha256de_pkg::word_t win_q [16];
	sha256de_pkg::word_t next_word;

	// next schedule word from the current window
	assign next_word = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	assign w_cur = win_q[0];

	// window shift, expansion and pad block load
	always_ff @(posedge clk) begin
		if (ctl.load_pad) begin
			for (int i = 0; i < 8; i++) begin
				win_q[i] <= pad_hash[i];
			end
			win_q[8] <= sha256de_pkg::PAD_FIRST;
			for (int i = 9; i < 15; i++) begin
				win_q[i] <= '0;
			end
			win_q[15] <= sha256de_pkg::PAD_LEN;
		end else if (ctl.shift_in || ctl.expand) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= ctl.expand ? next_word : in_word;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sha256de_round.sv =====
// ----------------------------------------------------------------------------
// sha256de_round
// working variables a..h and the shared compression round unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256de_round (
	input  wire                      clk,
	input  sha256de_pkg::round_ctl_t ctl,
	input  sha256de_pkg::hash_t      load_value,
	input  sha256de_pkg::word_t      k,
	input  sha256de_pkg::word_t      w,
	output sha256de_pkg::hash_t      work
);

	function automatic sha256de_pkg::word_t big_sigma0(input sha256de_pkg::word_t x);
		big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic sha256de_pkg::word_t big_sigma1(input sha256de_pkg::word_t x);
		big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	sha256de_pkg::hash_t work_q;
	sha256de_pkg::word_t t1;
	sha256de_pkg::word_t t2;
	sha256de_pkg::word_t ch;
	sha256de_pkg::word_t mj;

	// round function over a=0 .. h=7
	assign ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign mj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1 = work_q[7] + big_sigma1(work_q[4]) + ch + k + w;
	assign t2 = big_sigma0(work_q[0]) + mj;

	assign work = work_q;

	// load at block start, one round per step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			work_q <= load_value;
		end else if (ctl.step) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sha256_double_hash_engine_core.sv =====
// ----------------------------------------------------------------------------
// sha256_double_hash_engine_core
// sha-256 / double sha-256 over host-padded 32-bit big-endian message words
// ----------------------------------------------------------------------------
// Each 32-bit word is taken when in_valid is high and in_stall is low; the 16th
// word of a block starts the compression, which runs 64 rounds on a single
// round unit (one round per cycle) and then adds the result into the chain
// value; in_stall is high throughout the compression.
// first_block and last_block are only sampled on the 16th word of a block.
// After a final block an emit state, with in_stall still high, moves the
// digest into the output register once that register is free; with
// double_mode set (reset value) a second compression over the padded digest
// comes first, giving sha256d. The result sits in an output register, so new
// words are taken while it waits; a further digest waits for it.
// double_mode may only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "sha256_double_hash_engine_core_assert.svh"

module sha256_double_hash_engine_core (
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_write_en,
	input  wire        cfg_write_data,
	// input words
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [31:0] message_word,
	input  wire        first_block,
	input  wire        last_block,
	// digest
	output logic       out_valid,
	input  wire        out_stall,
	output logic [63:0] digest_part0,
	output logic [63:0] digest_part1,
	output logic [63:0] digest_part2,
	output logic [63:0] digest_part3
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FOLD  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t st_q;
	logic double_mode_q;
	logic [sha256de_pkg::POS_W-1:0] pos_q;
	logic [sha256de_pkg::ROUND_W-1:0] rnd_q;
	logic last_q;
	logic pass_q;
	logic out_valid_q;
	sha256de_pkg::hash_t chain_q;
	sha256de_pkg::hash_t out_digest_q;

	logic in_acc;
	logic block_start;
	logic load_pad;
	logic out_free;
	sha256de_pkg::hash_t start_hash;
	sha256de_pkg::hash_t fold_base;
	sha256de_pkg::hash_t fold_sum;
	sha256de_pkg::hash_t work;
	sha256de_pkg::word_t w_cur;
	sha256de_pkg::sched_ctl_t sched_ctl;
	sha256de_pkg::round_ctl_t round_ctl;

	// handshake decode
	assign in_stall = (st_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign block_start = in_acc && (pos_q == sha256de_pkg::LAST_POS);
	assign out_free = !out_valid_q || !out_stall;
	assign load_pad = (st_q == ST_FOLD) && !pass_q && last_q && double_mode_q;

	// chain value seen by a new block
	assign start_hash = first_block ? sha256de_pkg::IV_HASH : chain_q;

	// final addition, shared by both passes
	assign fold_base = pass_q ? sha256de_pkg::IV_HASH : chain_q;
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			fold_sum[i] = fold_base[i] + work[i];
		end
	end

	// control to the datapath units
	always_comb begin
		sched_ctl.shift_in = in_acc;
		sched_ctl.expand = (st_q == ST_ROUND);
		sched_ctl.load_pad = load_pad;
		round_ctl.load = block_start || load_pad;
		round_ctl.step = (st_q == ST_ROUND);
	end

	sha256de_sched u_sched (
		.clk      (clk),
		.ctl      (sched_ctl),
		.in_word  (message_word),
		.pad_hash (fold_sum),
		.w_cur    (w_cur)
	);

	sha256de_round u_round (
		.clk        (clk),
		.ctl        (round_ctl),
		.load_value (block_start ? start_hash : sha256de_pkg::IV_HASH),
		.k          (sha256de_pkg::K_ROM[rnd_q]),
		.w          (w_cur),
		.work       (work)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_mode_q <= 1'b1;
		end else if (cfg_write_en) begin
			double_mode_q <= cfg_write_data;
		end
	end

	// sequencer, word position, round counter and chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			pos_q <= '0;
			rnd_q <= '0;
			last_q <= 1'b0;
			pass_q <= 1'b0;
			chain_q <= sha256de_pkg::IV_HASH;
		end else begin
			if (in_acc) begin
				pos_q <= pos_q + 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					if (block_start) begin
						last_q <= last_block;
						chain_q <= start_hash;
						st_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == sha256de_pkg::LAST_ROUND) begin
						st_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (pass_q) begin
						st_q <= ST_EMIT;
					end else begin
						chain_q <= fold_sum;
						if (!last_q) begin
							st_q <= ST_IDLE;
						end else if (double_mode_q) begin
							pass_q <= 1'b1;
							st_q <= ST_ROUND;
						end else begin
							st_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						pass_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register data
	always_ff @(posedge clk) begin
		if ((st_q == ST_EMIT) && out_free) begin
			out_digest_q <= pass_q ? fold_sum : chain_q;
		end
	end

	assign out_valid = out_valid_q;
	assign digest_part0 = {out_digest_q[0], out_digest_q[1]};
	assign digest_part1 = {out_digest_q[2], out_digest_q[3]};
	assign digest_part2 = {out_digest_q[4], out_digest_q[5]};
	assign digest_part3 = {out_digest_q[6], out_digest_q[7]};

	// checks
	`SHA256DE_ASSERT(a_state_onehot, clk, arst_n, $onehot(st_q), "state not one-hot")
	`SHA256DE_ASSERT(a_rnd_idle, clk, arst_n, (st_q != ST_ROUND) |-> (rnd_q == '0), "round counter left running")
	`SHA256DE_ASSERT(a_block_start, clk, arst_n, block_start |=> (st_q == ST_ROUND), "block end did not start compression")
	`SHA256DE_ASSERT(a_pass_last, clk, arst_n, pass_q |-> (last_q && (st_q != ST_IDLE)), "second pass without final block")
	`SHA256DE_ASSERT(a_out_from_emit, clk, arst_n, $rose(out_valid_q) |-> $past(st_q == ST_EMIT), "digest presented outside emit")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: sha256_double_hash_engine_core testbench
// drives padded message words with random gaps and output stalls, computes
// the expected sha-256 / sha256d digests alongside and checks each digest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES = 500;
	localparam int MAX_REPORTS = 10;

	// sha-256 initial hash value, word 0 in the low bits
	localparam logic [255:0] SHA_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};
	localparam logic [31:0] PAD_MARK = 32'h80000000;
	localparam logic [31:0] PAD_BITS = 32'h00000100;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// part[3] is digest_part0, part[0] is digest_part3
	typedef struct packed {
		logic [3:0][63:0] part;
	} digest_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write_en;
	logic        cfg_write_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] message_word;
	logic        first_block;
	logic        last_block;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] digest_part0;
	logic [63:0] digest_part1;
	logic [63:0] digest_part2;
	logic [63:0] digest_part3;

	// digest model state
	logic [255:0] chain_model;
	logic [511:0] window_model;
	logic [3:0]   pos_model;
	logic         double_model;
	digest_t      expected_digests[$];

	int mismatches;
	int cycles;
	int send_idle_pct;
	int recv_stall_pct;
	logic hold_on;
	event hold_ev;

	sha256_double_hash_engine_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.message_word   (message_word),
		.first_block    (first_block),
		.last_block     (last_block),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digest_part0   (digest_part0),
		.digest_part1   (digest_part1),
		.digest_part2   (digest_part2),
		.digest_part3   (digest_part3)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression, result added into the chain value
	function automatic logic [255:0] sha256_compress(input logic [255:0] hin,
			input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, x, y;
		logic [255:0] hout;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = blk[32*i +: 32];
		for (i = 16; i < 64; i++) begin
			x = w[i-15];
			y = w[i-2];
			w[i] = (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10)) + w[i-7]
				+ (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-16];
		end
		a = hin[0 +: 32];
		b = hin[32 +: 32];
		c = hin[64 +: 32];
		d = hin[96 +: 32];
		e = hin[128 +: 32];
		f = hin[160 +: 32];
		g = hin[192 +: 32];
		hh = hin[224 +: 32];
		for (i = 0; i < 64; i++) begin
			t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
				+ ((e & f) ^ (~e & g)) + ROUND_K[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
				+ ((a & b) ^ (a & c) ^ (b & c));
			hh = g;
			g = f;
			f = e;
			e = d + t1;
			d = c;
			c = b;
			b = a;
			a = t1 + t2;
		end
		hout[0 +: 32] = hin[0 +: 32] + a;
		hout[32 +: 32] = hin[32 +: 32] + b;
		hout[64 +: 32] = hin[64 +: 32] + c;
		hout[96 +: 32] = hin[96 +: 32] + d;
		hout[128 +: 32] = hin[128 +: 32] + e;
		hout[160 +: 32] = hin[160 +: 32] + f;
		hout[192 +: 32] = hin[192 +: 32] + g;
		hout[224 +: 32] = hin[224 +: 32] + hh;
		return hout;
	endfunction

	// update the model with one accepted word, queue a digest when one is due
	task automatic absorb_word(input logic [31:0] w, input logic f, input logic l);
		logic [255:0] dig;
		logic [511:0] pad_blk;
		digest_t d;
		int k;
		window_model[pos_model*32 +: 32] = w;
		if (pos_model == 4'd15) begin
			if (f)
				chain_model = SHA_IV;
			chain_model = sha256_compress(chain_model, window_model);
			if (l) begin
				dig = chain_model;
				// second pass over the 32-byte digest with fixed padding
				if (double_model) begin
					pad_blk = '0;
					pad_blk[255:0] = chain_model;
					pad_blk[8*32 +: 32] = PAD_MARK;
					pad_blk[15*32 +: 32] = PAD_BITS;
					dig = sha256_compress(SHA_IV, pad_blk);
				end
				for (k = 0; k < 4; k++)
					d.part[3-k] = {dig[64*k +: 32], dig[64*k+32 +: 32]};
				expected_digests.push_back(d);
			end
		end
		pos_model = pos_model + 4'd1;
	endtask

	// digest checker
	always @(posedge clk) begin : check_digest
		digest_t got;
		digest_t want;
		int k;
		if (arst_n && out_valid && !out_stall) begin
			got.part = {digest_part0, digest_part1, digest_part2, digest_part3};
			if (expected_digests.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected digest %h", got.part);
			end else begin
				want = expected_digests.pop_front();
				for (k = 0; k < 4; k++) begin
					if (got.part[3-k] !== want.part[3-k]) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("digest_part%0d mismatch: expected %h actual %h",
								k, want.part[3-k], got.part[3-k]);
					end
				end
			end
		end
	end

	// receiver stall driver
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = hold_on || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// long receiver hold-off, counted in cycles
	initial begin
		hold_on = 1'b0;
		forever begin
			@(hold_ev);
			@(posedge clk);
			hold_on = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on = 1'b0;
		end
	end

	// random word with a bias toward the extremes
	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h00000000;
			1: return 32'hffffffff;
			2: return 32'h1 << $urandom_range(31);
			3: return ~(32'h1 << $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	// send one word transaction; called and returns at a falling edge
	task automatic send_word(input logic [31:0] w, input logic f, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			message_word = $urandom;
			first_block = 1'($urandom_range(1));
			last_block = 1'($urandom_range(1));
			@(negedge clk);
		end
		in_valid = 1'b1;
		message_word = w;
		first_block = f;
		last_block = l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		absorb_word(w, f, l);
		@(negedge clk);
	endtask

	// one message of nblocks blocks; broken messages get random marks
	task automatic send_message(input int nblocks, input bit broken);
		int b;
		int k;
		logic f;
		logic l;
		for (b = 0; b < nblocks; b++) begin
			for (k = 0; k < 16; k++) begin
				if (k == 15 && !broken) begin
					f = (b == 0);
					l = (b == nblocks - 1);
				end else begin
					f = 1'($urandom_range(1));
					l = 1'($urandom_range(1));
				end
				send_word(pick_word(), f, l);
			end
		end
	endtask

	// wait until every digest has arrived and the core has gone quiet
	task automatic drain_core();
		in_valid = 1'b0;
		while (expected_digests.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_double_mode(input logic v);
		drain_core();
		cfg_write_en = 1'b1;
		cfg_write_data = v;
		@(negedge clk);
		cfg_write_en = 1'b0;
		double_model = v;
	endtask

	// extreme words, continuation without first mark, ignored marks
	task automatic test_directed_blocks();
		int k;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// all-ones first block, marks on words 0..14 toggle and must be ignored
		for (k = 0; k < 15; k++)
			send_word(32'hffffffff, k[0], ~k[0]);
		send_word(32'hffffffff, 1'b1, 1'b0);
		// all-zeros final block continuing from the chain value
		for (k = 0; k < 15; k++)
			send_word(32'h00000000, 1'b1, 1'b1);
		send_word(32'h00000000, 1'b0, 1'b1);
		in_valid = 1'b0;
	endtask

	// random messages, mostly well formed, under the given idling and receiver stalls
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int n_items, input logic mode);
		int sent;
		int nb;
		int pick;
		set_double_mode(mode);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(9);
			nb = (pick < 6) ? 1 : (pick < 9) ? 2 : 3;
			send_message(nb, $urandom_range(9) == 0);
			sent += 16 * nb;
		end
		in_valid = 1'b0;
	endtask

	// receiver holds off while words keep coming, so the core backs up
	task automatic test_output_backpressure();
		int m;
		set_double_mode(1'($urandom_range(1)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		-> hold_ev;
		for (m = 0; m < 6; m++)
			send_message(1, 1'b0);
		in_valid = 1'b0;
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = 1'b0;
		in_valid = 1'b0;
		message_word = '0;
		first_block = 1'b0;
		last_block = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		chain_model = SHA_IV;
		window_model = '0;
		pos_model = '0;
		double_model = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_blocks();
		test_random_traffic(0, 0, 224, 1'b0);
		test_random_traffic(66, 0, 224, 1'b1);
		test_random_traffic(0, 66, 224, 1'b0);
		test_random_traffic(30, 30, 224, 1'b1);
		test_output_backpressure();

		drain_core();
		if (mismatches == 0 && expected_digests.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sha256de_pkg.sv
rtl/core/sha256de_sched.sv
rtl/core/sha256de_round.sv
rtl/core/sha256_double_hash_engine_core.sv
test/tb.sv
